// ===== rtl/ilt_pkg.sv =====
package ilt_pkg;

  // Default sizes of the list.
  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed payload field widths.
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } ilt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [FOUND_W-1:0]  found_position;
    logic [COUNT_W-1:0]  count;
  } ilt_out_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic era_en;
  } ilt_cell_ctrl_t;

endpackage

// ===== rtl/ilt_cell.sv =====
module ilt_cell #(
  parameter int INDEX = 0,
  parameter int EW    = 32,
  parameter int CMP_W = 7
) (
  input  logic                    clk,
  input  ilt_pkg::ilt_cell_ctrl_t ctrl,
  input  logic [CMP_W-1:0]        pos,
  input  logic [CMP_W-1:0]        count,
  input  logic [EW-1:0]           val,
  input  logic [EW-1:0]           prev_entry,
  input  logic [EW-1:0]           next_entry,
  output logic [EW-1:0]           entry,
  output logic                    match,
  output logic [EW-1:0]           rd_data
);
  import ilt_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic [EW-1:0] entry_r;

  // Insert moves entries above the position up one place and writes the new
  // value at the position; erase pulls entries from the position upwards down.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (MY_IDX > pos) begin
        entry_r <= prev_entry;
      end else if (MY_IDX == pos) begin
        entry_r <= val;
      end
    end else if (ctrl.era_en) begin
      if (MY_IDX >= pos) begin
        entry_r <= next_entry;
      end
    end
  end

  // A live entry that equals the search value flags a match.
  assign match   = (MY_IDX < count) && (entry_r == val);
  assign rd_data = (MY_IDX == pos) ? entry_r : '0;
  assign entry   = entry_r;

endmodule

// ===== rtl/indexed_list_table_core.sv =====
// Indexed list table: an ordered list held in a chain of entry cells.
// A request is executed in S_EXEC and its result registered in S_FIN once the
// output slot is free; the next request is taken then, not before. Insert and
// erase shift the whole chain in S_EXEC; find picks the first match in S_FIN.
// Reset: synchronous, active low; clears the count and the handshake state.
module indexed_list_table_core #(
  parameter int CAPACITY      = ilt_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ilt_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ilt_pkg::ilt_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ilt_pkg::ilt_out_t out_data
);
  import ilt_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t             state_r;
  logic [FUNC_W-1:0]  func_r;
  logic [POS_W-1:0]   pos_r;
  logic [EW-1:0]      val_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STATUS_W-1:0] stat_r;
  logic [EW-1:0]      rdata_r;
  logic [CAPACITY-1:0] match_r;
  logic               out_valid_r;
  ilt_out_t           out_r;

  logic [EW-1:0]      val_in;
  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   cnt_c;
  logic               slot_free;
  logic               ins_ok;
  logic               era_ok;
  logic               rd_ok;
  logic [STATUS_W-1:0] stat_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  ilt_cell_ctrl_t     ctrl;
  logic [EW-1:0]      cell_entry [CAPACITY];
  logic [EW-1:0]      cell_rd [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  logic [EW-1:0]      rd_or;
  logic [CAPACITY-1:0] low_bit;
  logic [IDX_W-1:0]   first_idx;
  logic               any_match;
  logic [VALUE_W-1:0] data_o;
  logic [FOUND_W-1:0] found_o;
  logic [COUNT_W-1:0] count_o;
  ilt_out_t           res_nxt;

  // Request value: low element bits kept, or zero-extended for wider elements.
  if (EW <= VALUE_W) begin : g_val_narrow
    assign val_in = in_data.value[EW-1:0];
    if (EW < VALUE_W) begin : g_data_ext
      assign data_o = {{(VALUE_W-EW){1'b0}}, rdata_r};
    end else begin : g_data_eq
      assign data_o = rdata_r;
    end
  end else begin : g_val_wide
    assign val_in = {{(EW-VALUE_W){1'b0}}, in_data.value};
    assign data_o = rdata_r[VALUE_W-1:0];
  end

  // Count and position brought to a common compare width.
  if (CMP_W > POS_W) begin : g_pos_ext
    assign pos_c = {{(CMP_W-POS_W){1'b0}}, pos_r};
  end else begin : g_pos_eq
    assign pos_c = pos_r;
  end
  if (CMP_W > CNT_W) begin : g_cnt_ext
    assign cnt_c = {{(CMP_W-CNT_W){1'b0}}, cnt_r};
  end else begin : g_cnt_eq
    assign cnt_c = cnt_r;
  end

  // Result fields narrowed or widened to their port widths.
  if (IDX_W >= FOUND_W) begin : g_found_cut
    assign found_o = any_match ? first_idx[FOUND_W-1:0] : '0;
  end else begin : g_found_ext
    assign found_o = any_match ? {{(FOUND_W-IDX_W){1'b0}}, first_idx} : '0;
  end
  if (CNT_W >= COUNT_W) begin : g_count_cut
    assign count_o = cnt_r[COUNT_W-1:0];
  end else begin : g_count_ext
    assign count_o = {{(COUNT_W-CNT_W){1'b0}}, cnt_r};
  end

  // Range and capacity checks for the request being executed.
  always_comb begin
    ins_ok   = 1'b0;
    era_ok   = 1'b0;
    rd_ok    = 1'b0;
    stat_nxt = STAT_OK;
    cnt_nxt  = cnt_r;
    unique case (func_r)
      FUNC_INSERT: begin
        if (pos_c > cnt_c) begin
          stat_nxt = STAT_BAD_INDEX;
        end else if (cnt_c >= CAP_C) begin
          stat_nxt = STAT_FULL;
        end else begin
          ins_ok  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      FUNC_ERASE: begin
        if (pos_c >= cnt_c) begin
          stat_nxt = STAT_BAD_INDEX;
        end else begin
          era_ok  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      FUNC_READ: begin
        if (pos_c >= cnt_c) begin
          stat_nxt = STAT_BAD_INDEX;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        stat_nxt = STAT_NOT_FOUND;
      end
    endcase
  end

  assign ctrl.ins_en = (state_r == S_EXEC) && ins_ok;
  assign ctrl.era_en = (state_r == S_EXEC) && era_ok;

  // The chain of entry cells, each fed by its two neighbours.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EW-1:0] prev_e;
    logic [EW-1:0] next_e;
    if (g == 0) begin : g_first
      assign prev_e = val_r;
    end else begin : g_mid_lo
      assign prev_e = cell_entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_hi
      assign next_e = cell_entry[g+1];
    end
    ilt_cell #(
      .INDEX (g),
      .EW    (EW),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos_c),
      .count      (cnt_c),
      .val        (val_r),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cell_entry[g]),
      .match      (match_w[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // Only the addressed cell drives a non-zero read word.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Isolate the lowest match bit and encode its position.
  assign low_bit   = match_r & (~match_r + CAPACITY'(1));
  assign any_match = |match_r;
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (low_bit[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  // Result assembled from the executed request.
  always_comb begin
    res_nxt.data           = data_o;
    res_nxt.count          = count_o;
    res_nxt.found_position = '0;
    res_nxt.status         = stat_r;
    if (func_r == FUNC_FIND) begin
      res_nxt.status         = any_match ? STAT_OK : STAT_NOT_FOUND;
      res_nxt.found_position = found_o;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_FIN) && slot_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: accept, execute on the chain, then hand over the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the final state a taken result is replaced by the next one below.
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_data.func;
            pos_r   <= in_data.position;
            val_r   <= val_in;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_r   <= cnt_nxt;
          stat_r  <= stat_nxt;
          match_r <= match_w;
          rdata_r <= rd_ok ? rd_or : '0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            if (in_valid) begin
              func_r  <= in_data.func;
              pos_r   <= in_data.position;
              val_r   <= val_in;
              state_r <= S_EXEC;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ilt_pkg::*;

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int ELEM_W          = ELEMENT_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 2000;
  localparam int DRAIN_EVERY     = 400;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PRINT_CAP       = 200;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

  // Shadow copy of the list plus the queue of outcomes still owed by the block.
  class list_scoreboard;
    logic [ELEM_W-1:0] shadow_entries [CAPACITY];
    int                shadow_count;
    ilt_out_t          awaited_outcomes [$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      shadow_count = 0;
      mismatches   = 0;
      results_seen = 0;
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
    endfunction

    function int fill();
      return shadow_count;
    endfunction

    function int pending();
      return awaited_outcomes.size();
    endfunction

    function logic [VALUE_W-1:0] entry_at(int idx);
      return VALUE_W'(shadow_entries[idx]);
    endfunction

    // Applies one request to the shadow list and returns the outcome it gives.
    function ilt_out_t list_outcome(ilt_in_t req);
      ilt_out_t          res;
      int                pos;
      logic [ELEM_W-1:0] val;
      bit                hit;
      res    = '0;
      pos    = int'(req.position);
      val    = req.value[ELEM_W-1:0];
      hit    = 1'b0;
      res.status = STAT_OK;
      case (req.func)
        FUNC_INSERT: begin
          // The position check takes priority over the full check.
          if (pos > shadow_count) begin
            res.status = STAT_BAD_INDEX;
          end else if (shadow_count >= CAPACITY) begin
            res.status = STAT_FULL;
          end else begin
            for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos] = val;
            shadow_count++;
          end
        end
        FUNC_ERASE: begin
          if (pos >= shadow_count) begin
            res.status = STAT_BAD_INDEX;
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
            shadow_entries[shadow_count] = '0;
          end
        end
        FUNC_READ: begin
          if (pos >= shadow_count) begin
            res.status = STAT_BAD_INDEX;
          end else begin
            res.data = VALUE_W'(shadow_entries[pos]);
          end
        end
        default: begin
          // Only live entries are searched, and the lowest match wins.
          res.status = STAT_NOT_FOUND;
          for (int i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_entries[i] == val) begin
              hit                = 1'b1;
              res.status         = STAT_OK;
              res.found_position = FOUND_W'(i);
            end
          end
        end
      endcase
      res.count = COUNT_W'(shadow_count);
      return res;
    endfunction

    function void note_request(ilt_in_t req);
      awaited_outcomes.push_back(list_outcome(req));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("mismatch at result %0d: %s is %0h, should be %0h",
                 results_seen, what, got, want);
      end
    endtask

    task check_result(ilt_out_t got);
      ilt_out_t want;
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        report("result with no request outstanding", 64'(got), 64'(0));
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
        if (got.data !== want.data) report("data", 64'(got.data), 64'(want.data));
        if (got.found_position !== want.found_position) begin
          report("found_position", 64'(got.found_position), 64'(want.found_position));
        end
        if (got.count !== want.count) report("count", 64'(got.count), 64'(want.count));
      end
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ilt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ilt_out_t out_data;

  list_scoreboard sb;
  bit             burst_mode = 1'b0;
  int             quiet_cycles = 0;
  int             sink_hold = 0;
  bit             sink_on = 1'b1;

  indexed_list_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are observed at the rising edge; the watchdog counts idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Result side back-pressure: runs of readiness, short stalls and the odd long one.
  always @(negedge clk) begin
    int roll;
    if (sink_hold == 0) begin
      roll = int'($urandom_range(0, 99));
      if (roll < 40) begin
        sink_on   = 1'b1;
        sink_hold = int'($urandom_range(1, 30));
      end else if (roll < 88) begin
        sink_on   = 1'b0;
        sink_hold = int'($urandom_range(1, 3));
      end else if (roll < 97) begin
        sink_on   = 1'b0;
        sink_hold = int'($urandom_range(4, 10));
      end else begin
        sink_on   = 1'b0;
        sink_hold = int'($urandom_range(20, 40));
      end
    end else begin
      sink_hold--;
    end
    out_ready <= sink_on;
  end

  function automatic ilt_in_t request_of(logic [FUNC_W-1:0] func, int pos,
                                         logic [VALUE_W-1:0] val);
    ilt_in_t req;
    req.func     = func;
    req.position = POS_W'(pos);
    req.value    = val;
    return req;
  endfunction

  // Builds a random request, steered by the traffic mode and the current fill.
  function automatic ilt_in_t pick_request(traffic_mode_t mode);
    ilt_in_t req;
    int      fill;
    int      top;
    int      roll;
    int      ins_cut;
    int      era_cut;
    int      rd_cut;
    fill = sb.fill();
    case (mode)
      MODE_GROW: begin
        ins_cut = 70; era_cut = 76; rd_cut = 88;
      end
      MODE_SHRINK: begin
        ins_cut = 10; era_cut = 70; rd_cut = 85;
      end
      default: begin
        ins_cut = 30; era_cut = 55; rd_cut = 78;
      end
    endcase
    roll = int'($urandom_range(0, 99));
    if (roll < ins_cut) begin
      req.func = FUNC_INSERT;
    end else if (roll < era_cut) begin
      req.func = FUNC_ERASE;
    end else if (roll < rd_cut) begin
      req.func = FUNC_READ;
    end else begin
      req.func = FUNC_FIND;
    end

    // Mostly legal positions, with misses just past the end and far beyond it.
    top = (req.func == FUNC_INSERT) ? fill : fill - 1;
    if (req.func == FUNC_FIND) begin
      req.position = POS_W'($urandom_range(0, 127));
    end else if (top >= 0 && $urandom_range(0, 99) < 85) begin
      req.position = POS_W'($urandom_range(0, top));
    end else if ($urandom_range(0, 1) == 1) begin
      req.position = POS_W'(top + 1 + int'($urandom_range(0, 2)));
    end else begin
      req.position = POS_W'($urandom_range(top + 1, 127));
    end

    // A small pool of values makes duplicates, so find must pick the first.
    roll = int'($urandom_range(0, 99));
    if (req.func == FUNC_FIND && fill > 0 && roll < 50) begin
      req.value = sb.entry_at(int'($urandom_range(0, fill - 1)));
    end else if (roll < 35) begin
      req.value = VALUE_W'($urandom_range(0, 7));
    end else if (roll < 45) begin
      req.value = ($urandom_range(0, 1) == 1) ? '1 : '0;
    end else begin
      req.value = $urandom;
    end
    return req;
  endfunction

  // Presents a request and holds it until the block takes it.
  task automatic send_request(ilt_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random gap after a request, with noise on the idle payload.
  task automatic pace();
    int          roll;
    int          gap;
    logic [63:0] noise;
    roll = int'($urandom_range(0, 99));
    if (burst_mode || roll < 55) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = int'($urandom_range(1, 3));
    end else if (roll < 98) begin
      gap = int'($urandom_range(4, 10));
    end else begin
      gap = int'($urandom_range(20, 60));
    end
    if (gap > 0) begin
      noise    = {$urandom, $urandom};
      in_valid <= 1'b0;
      in_data  <= noise[$bits(ilt_in_t)-1:0];
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue(ilt_in_t req);
    send_request(req);
    pace();
  endtask

  // The sender holds off until every outstanding request has been answered.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    traffic_mode_t mode;
    int            sent;
    int            last_drain;
    int            phase_len;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, past-the-end insert, front, middle and end inserts,
    // duplicates, finds with and without a match, and erases at each end.
    issue(request_of(FUNC_READ,   0,   32'h0000_0000));
    issue(request_of(FUNC_ERASE,  0,   32'h0000_0000));
    issue(request_of(FUNC_FIND,   0,   32'h0000_0000));
    issue(request_of(FUNC_INSERT, 1,   32'h1111_1111));
    issue(request_of(FUNC_INSERT, 127, 32'h2222_2222));
    issue(request_of(FUNC_INSERT, 0,   32'hFFFF_FFFF));
    issue(request_of(FUNC_INSERT, 1,   32'h0000_0000));
    issue(request_of(FUNC_INSERT, 0,   32'hA5A5_A5A5));
    issue(request_of(FUNC_INSERT, 1,   32'h5A5A_5A5A));
    issue(request_of(FUNC_INSERT, 0,   32'hFFFF_FFFF));
    issue(request_of(FUNC_FIND,   127, 32'hFFFF_FFFF));
    issue(request_of(FUNC_FIND,   64,  32'h0000_0000));
    issue(request_of(FUNC_FIND,   0,   32'h1234_5678));
    issue(request_of(FUNC_READ,   0,   32'h0000_0000));
    issue(request_of(FUNC_READ,   4,   32'h0000_0000));
    issue(request_of(FUNC_READ,   5,   32'h0000_0000));
    issue(request_of(FUNC_READ,   64,  32'h0000_0000));
    issue(request_of(FUNC_ERASE,  0,   32'h0000_0000));
    issue(request_of(FUNC_ERASE,  3,   32'h0000_0000));
    issue(request_of(FUNC_ERASE,  3,   32'h0000_0000));
    issue(request_of(FUNC_FIND,   0,   32'h0000_0000));
    issue(request_of(FUNC_ERASE,  1,   32'h0000_0000));
    issue(request_of(FUNC_INSERT, 2,   32'h8000_0001));
    issue(request_of(FUNC_READ,   1,   32'h0000_0000));
    drain();

    // Fill the list with random inserts, then push against the full limit.
    while (sb.fill() < CAPACITY) begin
      issue(request_of(FUNC_INSERT, int'($urandom_range(0, sb.fill())), $urandom));
    end
    issue(request_of(FUNC_INSERT, CAPACITY,     $urandom));
    issue(request_of(FUNC_INSERT, 0,            $urandom));
    issue(request_of(FUNC_INSERT, CAPACITY + 1, $urandom));
    issue(request_of(FUNC_READ,   CAPACITY - 1, $urandom));
    issue(request_of(FUNC_FIND,   0,            sb.entry_at(CAPACITY - 1)));
    issue(request_of(FUNC_ERASE,  CAPACITY,     $urandom));

    // Random phases of growth, shrinkage and mixed traffic.
    sent       = 0;
    last_drain = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode       = traffic_mode_t'($urandom_range(0, 2));
      phase_len  = int'($urandom_range(40, 160));
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        issue(pick_request(mode));
        sent++;
      end
      if (sent - last_drain >= DRAIN_EVERY) begin
        drain();
        last_drain = sent;
      end
    end

    // Wait for the last results, then allow the pipeline to settle.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
